>>> hw/rtl/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, codes and widths for the spring force accumulator.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int DIMENSIONS_DEF = 3;

    localparam int PT_W  = 10;
    localparam int POS_W = 32;
    localparam int SUM_W = 48;
    localparam int MUL_W = 24;

    // shared add/subtract unit and its operands
    localparam int ALU_W  = 124;
    localparam int MAG_W  = 33;
    localparam int ROOT_W = 34;
    localparam int REM_W  = 36;
    localparam int MPLR_W = 34;
    localparam int P1_W   = 91;
    localparam int QUO_W  = 31;
    localparam int CNT_W  = 6;

    localparam logic [MPLR_W-1:0] UNIT_MULT = MPLR_W'(65536);
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic CFG_FORCE_TYPE = 1'b0;
    localparam logic CFG_STIFFNESS  = 1'b1;

    localparam logic [1:0] FT_NONE    = 2'd0;
    localparam logic [1:0] FT_UNIFORM = 2'd1;
    localparam logic [1:0] FT_SCALED  = 2'd2;

    localparam logic MODE_SPRING = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [3:0] {
        F_IDLE, F_SQ, F_ROOT, F_PREP, F_KM, F_KE, F_AXIS, F_DIV, F_MUL, F_DONE
    } t_fstate;

    typedef enum logic [3:0] {
        T_CLEAR, T_IDLE, T_RD0, T_RD1, T_CALC, T_U0A, T_U0B, T_U1A, T_U1B
    } t_tstate;

    typedef struct packed {
        logic                    done;
        logic                    apply;
        logic signed [SUM_W-1:0] fx;
        logic signed [SUM_W-1:0] fy;
        logic signed [SUM_W-1:0] fz;
    } t_force_res;

endpackage
`default_nettype wire

>>> hw/rtl/sfa_force.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfa_force
// Spring force per axis on one shift-and-add unit: squares, square root,
// stiffness product, unit vector division and force product, bit by bit.
// ----------------------------------------------------------------------------
module sfa_force #(
    parameter int DIMENSIONS = sfa_pkg::DIMENSIONS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic                            i_scaled,
    input  wire logic [31:0]                     i_stiffness,
    input  wire logic [sfa_pkg::MUL_W-1:0]       i_multiplier,
    input  wire logic [31:0]                     i_rest_length,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_first_x,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_first_y,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_first_z,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_second_x,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_second_y,
    input  wire logic signed [sfa_pkg::POS_W-1:0] i_second_z,
    output sfa_pkg::t_force_res                  o_res
);

    localparam int W = sfa_pkg::ALU_W;

    sfa_pkg::t_fstate r_state, n_state;
    logic [sfa_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]                 r_axis, n_axis;
    logic [sfa_pkg::MAG_W-1:0]  r_mag [0:3];
    logic [sfa_pkg::MAG_W-1:0]  n_mag [0:3];
    logic [3:0]                 r_dneg, n_dneg;
    logic [W-1:0]               r_acc, n_acc;
    logic [W-1:0]               r_mcand, n_mcand;
    logic [sfa_pkg::MPLR_W-1:0] r_mplr, n_mplr;
    logic [sfa_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [sfa_pkg::ROOT_W-1:0] r_root, n_root;
    logic [sfa_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic [sfa_pkg::P1_W-1:0]   r_p1, n_p1;
    logic [sfa_pkg::ROOT_W-1:0] r_ext_mag, n_ext_mag;
    logic                       r_ext_neg, n_ext_neg;
    logic                       r_apply, n_apply;
    logic [sfa_pkg::MUL_W-1:0]  r_mult, n_mult;
    logic [31:0]                r_l0, n_l0;
    logic signed [sfa_pkg::SUM_W-1:0] r_f [0:2];
    logic signed [sfa_pkg::SUM_W-1:0] n_f [0:2];

    logic [W-1:0]               alu_a, alu_b, alu_y;
    logic                       alu_sub, alu_ge;
    logic [sfa_pkg::REM_W+1:0]  root_in;
    logic [1:0]                 sel_axis;
    logic [sfa_pkg::MAG_W-1:0]  mag_sel;
    logic [sfa_pkg::MAG_W:0]    dm_x, dm_y, dm_z;
    logic signed [35:0]         ext;
    logic [35:0]                ext_abs;
    logic [59:0]                prod_hi;
    logic [sfa_pkg::SUM_W-1:0]  f_mag;
    logic signed [sfa_pkg::SUM_W-1:0] f_val;

    // {sign, magnitude} of second minus first
    function automatic logic [sfa_pkg::MAG_W:0] diff_mag(
        input logic signed [sfa_pkg::POS_W-1:0] a,
        input logic signed [sfa_pkg::POS_W-1:0] b
    );
        logic signed [sfa_pkg::MAG_W-1:0] d;
        d = {b[sfa_pkg::POS_W-1], b} - {a[sfa_pkg::POS_W-1], a};
        diff_mag = {d[sfa_pkg::MAG_W-1], d[sfa_pkg::MAG_W-1] ? -d : d};
    endfunction

    assign dm_x = diff_mag(i_first_x, i_second_x);
    assign dm_y = diff_mag(i_first_y, i_second_y);
    assign dm_z = (DIMENSIONS == 3) ? diff_mag(i_first_z, i_second_z)
                                    : '0;

    assign sel_axis = (r_state == sfa_pkg::F_SQ) ? r_axis + 2'd1 : r_axis;
    assign mag_sel  = r_mag[sel_axis];

    assign ext     = 36'(r_root) - 36'(r_l0);
    assign ext_abs = ext[35] ? 36'(-ext) : 36'(ext);

    assign prod_hi = r_acc[121:62];
    assign f_mag   = (|prod_hi[59:47]) ? sfa_pkg::SUM_MAX : {1'b0, prod_hi[46:0]};
    assign f_val   = (r_ext_neg ^ r_dneg[r_axis]) ? -$signed(f_mag) : $signed(f_mag);

    always_comb begin
        root_in = {r_rem, r_acc[67:66]};
        alu_a   = r_acc;
        alu_b   = r_mcand;
        alu_sub = 1'b0;
        case (r_state)
            sfa_pkg::F_ROOT: begin
                alu_a   = W'(root_in);
                alu_b   = W'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            sfa_pkg::F_DIV: begin
                alu_a   = W'(r_rem);
                alu_b   = W'(r_root);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign alu_y  = alu_sub ? alu_a - alu_b : alu_a + alu_b;
    assign alu_ge = ~alu_y[W-1];

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_axis    = r_axis;
        n_mag     = r_mag;
        n_dneg    = r_dneg;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_mplr    = r_mplr;
        n_rem     = r_rem;
        n_root    = r_root;
        n_quo     = r_quo;
        n_p1      = r_p1;
        n_ext_mag = r_ext_mag;
        n_ext_neg = r_ext_neg;
        n_apply   = r_apply;
        n_mult    = r_mult;
        n_l0      = r_l0;
        n_f       = r_f;

        // shift-and-add step shared by all products
        if ((r_state == sfa_pkg::F_SQ || r_state == sfa_pkg::F_KM ||
             r_state == sfa_pkg::F_KE || r_state == sfa_pkg::F_MUL) && r_cnt != '0) begin
            if (r_mplr[0]) begin
                n_acc = alu_y;
            end
            n_mcand = r_mcand << 1;
            n_mplr  = r_mplr >> 1;
            n_cnt   = r_cnt - 1'b1;
        end

        case (r_state)
            sfa_pkg::F_IDLE: begin
                if (i_start) begin
                    n_mag[0] = dm_x[sfa_pkg::MAG_W-1:0];
                    n_mag[1] = dm_y[sfa_pkg::MAG_W-1:0];
                    n_mag[2] = dm_z[sfa_pkg::MAG_W-1:0];
                    n_mag[3] = '0;
                    n_dneg   = {1'b0, dm_z[sfa_pkg::MAG_W], dm_y[sfa_pkg::MAG_W],
                                dm_x[sfa_pkg::MAG_W]};
                    n_mult   = i_multiplier;
                    n_l0     = i_rest_length;
                    n_f[0]   = '0;
                    n_f[1]   = '0;
                    n_f[2]   = '0;
                    n_acc    = '0;
                    n_mcand  = W'(dm_x[sfa_pkg::MAG_W-1:0]);
                    n_mplr   = sfa_pkg::MPLR_W'(dm_x[sfa_pkg::MAG_W-1:0]);
                    n_cnt    = sfa_pkg::CNT_W'(sfa_pkg::MAG_W);
                    n_axis   = '0;
                    n_apply  = 1'b0;
                    n_state  = sfa_pkg::F_SQ;
                end
            end
            sfa_pkg::F_SQ: begin
                if (r_cnt == '0) begin
                    if (r_axis == 2'(DIMENSIONS - 1)) begin
                        n_rem   = '0;
                        n_root  = '0;
                        n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::ROOT_W);
                        n_state = sfa_pkg::F_ROOT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_mcand = W'(mag_sel);
                        n_mplr  = sfa_pkg::MPLR_W'(mag_sel);
                        n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::MAG_W);
                    end
                end
            end
            sfa_pkg::F_ROOT: begin
                if (r_cnt != '0) begin
                    n_acc = r_acc << 2;
                    if (alu_ge) begin
                        n_rem  = alu_y[sfa_pkg::REM_W-1:0];
                        n_root = {r_root[sfa_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = root_in[sfa_pkg::REM_W-1:0];
                        n_root = {r_root[sfa_pkg::ROOT_W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = sfa_pkg::F_PREP;
                end
            end
            sfa_pkg::F_PREP: begin
                n_ext_neg = ext[35];
                n_ext_mag = ext_abs[sfa_pkg::ROOT_W-1:0];
                if (r_root == '0) begin
                    n_state = sfa_pkg::F_DONE;
                end else begin
                    n_apply = 1'b1;
                    n_acc   = '0;
                    n_mcand = W'(i_stiffness);
                    n_mplr  = i_scaled ? sfa_pkg::MPLR_W'(r_mult) : sfa_pkg::UNIT_MULT;
                    n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::MUL_W);
                    n_state = sfa_pkg::F_KM;
                end
            end
            sfa_pkg::F_KM: begin
                if (r_cnt == '0) begin
                    n_acc   = '0;
                    n_mcand = r_acc;
                    n_mplr  = r_ext_mag;
                    n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::ROOT_W);
                    n_state = sfa_pkg::F_KE;
                end
            end
            sfa_pkg::F_KE: begin
                if (r_cnt == '0) begin
                    n_p1    = r_acc[sfa_pkg::P1_W-1:0];
                    n_axis  = '0;
                    n_state = sfa_pkg::F_AXIS;
                end
            end
            sfa_pkg::F_AXIS: begin
                if (r_axis == 2'(DIMENSIONS)) begin
                    n_state = sfa_pkg::F_DONE;
                end else if (mag_sel == '0 || r_ext_mag == '0) begin
                    n_axis = r_axis + 2'd1;
                end else begin
                    n_rem   = sfa_pkg::REM_W'(mag_sel);
                    n_quo   = '0;
                    n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::QUO_W);
                    n_state = sfa_pkg::F_DIV;
                end
            end
            sfa_pkg::F_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = alu_ge ? {alu_y[sfa_pkg::REM_W-2:0], 1'b0}
                                   : {r_rem[sfa_pkg::REM_W-2:0], 1'b0};
                    n_quo = {r_quo[sfa_pkg::QUO_W-2:0], alu_ge};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_acc   = '0;
                    n_mcand = W'(r_p1);
                    n_mplr  = sfa_pkg::MPLR_W'(r_quo);
                    n_cnt   = sfa_pkg::CNT_W'(sfa_pkg::QUO_W);
                    n_state = sfa_pkg::F_MUL;
                end
            end
            sfa_pkg::F_MUL: begin
                if (r_cnt == '0) begin
                    n_f[r_axis] = f_val;
                    n_axis      = r_axis + 2'd1;
                    n_state     = sfa_pkg::F_AXIS;
                end
            end
            sfa_pkg::F_DONE: begin
                n_state = sfa_pkg::F_IDLE;
            end
            default: begin
                n_state = sfa_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfa_pkg::F_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_apply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_apply <= n_apply;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_dneg    <= n_dneg;
        r_acc     <= n_acc;
        r_mcand   <= n_mcand;
        r_mplr    <= n_mplr;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_quo     <= n_quo;
        r_p1      <= n_p1;
        r_ext_mag <= n_ext_mag;
        r_ext_neg <= n_ext_neg;
        r_mult    <= n_mult;
        r_l0      <= n_l0;
        r_f       <= n_f;
    end

    assign o_res.done  = (r_state == sfa_pkg::F_DONE);
    assign o_res.apply = r_apply;
    assign o_res.fx    = r_f[0];
    assign o_res.fy    = r_f[1];
    assign o_res.fz    = r_f[2];

endmodule
`default_nettype wire

>>> hw/rtl/spring_force_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spring_force_accumulator
// Per-point Hookean spring force sums with saturating read-modify-write.
// ----------------------------------------------------------------------------
// After reset the block sweeps the force store to zero, one point per cycle,
// with busy high. A read transfer puts its result on the outputs for exactly
// one cycle with o_valid; the receiver cannot hold it off. A spring transfer
// runs setup, a square per axis, the root, the stiffness product, the
// extension product, a divide and multiply per nonzero axis, the hand-off
// and the store update, with the arithmetic on the single shift-and-add unit
// in sfa_force. Springs with force type none are dropped in the cycle they
// arrive.
// ----------------------------------------------------------------------------
module spring_force_accumulator #(
    parameter int MAX_POINTS = sfa_pkg::MAX_POINTS_DEF,
    parameter int DIMENSIONS = sfa_pkg::DIMENSIONS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_idx,
    input  wire logic [31:0]                       i_cfg_data,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_mode,
    input  wire logic [sfa_pkg::PT_W-1:0]          i_first_point,
    input  wire logic [sfa_pkg::PT_W-1:0]          i_second_point,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_first_x,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_first_y,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_first_z,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_second_x,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_second_y,
    input  wire logic signed [sfa_pkg::POS_W-1:0]  i_second_z,
    input  wire logic [31:0]                       i_rest_length,
    input  wire logic [sfa_pkg::MUL_W-1:0]         i_multiplier,
    output logic                                   o_valid,
    output logic [sfa_pkg::PT_W-1:0]               o_point,
    output logic signed [sfa_pkg::SUM_W-1:0]       o_total_x,
    output logic signed [sfa_pkg::SUM_W-1:0]       o_total_y,
    output logic signed [sfa_pkg::SUM_W-1:0]       o_total_z
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW = sfa_pkg::SUM_W;

    sfa_pkg::t_tstate r_state, n_state;
    logic [AW-1:0]              r_clr, n_clr;
    logic [1:0]                 r_force_type;
    logic [31:0]                r_stiffness;
    logic [sfa_pkg::PT_W-1:0]   r_p0, r_p1;
    logic                       r_in0, r_in1;

    logic [3*SW-1:0]            mem [0:MAX_POINTS-1];
    logic [3*SW-1:0]            r_rdata;
    logic [AW-1:0]              mem_raddr, mem_waddr;
    logic [3*SW-1:0]            mem_wdata;
    logic                       mem_we;

    logic                       accept, type_ok, force_start;
    sfa_pkg::t_force_res        res;

    function automatic logic [SW-1:0] sat_add(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b
    );
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            sat_add = s[SW] ? sfa_pkg::SUM_MIN : sfa_pkg::SUM_MAX;
        end else begin
            sat_add = s[SW-1:0];
        end
    endfunction

    assign accept      = i_start && !o_busy;
    assign type_ok     = (r_force_type == sfa_pkg::FT_UNIFORM) ||
                         (r_force_type == sfa_pkg::FT_SCALED);
    assign force_start = accept && (i_mode == sfa_pkg::MODE_SPRING) && type_ok;

    sfa_force #(
        .DIMENSIONS (DIMENSIONS)
    ) u_force (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (force_start),
        .i_scaled      (r_force_type == sfa_pkg::FT_SCALED),
        .i_stiffness   (r_stiffness),
        .i_multiplier  (i_multiplier),
        .i_rest_length (i_rest_length),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_first_z     (i_first_z),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_second_z    (i_second_z),
        .o_res         (res)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_p0);
        mem_wdata = '0;
        mem_raddr = AW'(r_p0);
        case (r_state)
            sfa_pkg::T_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(MAX_POINTS - 1)) begin
                    n_state = sfa_pkg::T_IDLE;
                end
            end
            sfa_pkg::T_IDLE: begin
                if (accept) begin
                    if (i_mode == sfa_pkg::MODE_READ) begin
                        n_state = sfa_pkg::T_RD0;
                    end else if (type_ok) begin
                        n_state = sfa_pkg::T_CALC;
                    end
                end
            end
            sfa_pkg::T_RD0: begin
                n_state = sfa_pkg::T_RD1;
            end
            sfa_pkg::T_RD1: begin
                mem_we  = r_in0;
                n_state = sfa_pkg::T_IDLE;
            end
            sfa_pkg::T_CALC: begin
                if (res.done) begin
                    n_state = res.apply ? sfa_pkg::T_U0A : sfa_pkg::T_IDLE;
                end
            end
            sfa_pkg::T_U0A: begin
                n_state = sfa_pkg::T_U0B;
            end
            sfa_pkg::T_U0B: begin
                mem_we    = r_in0;
                mem_wdata = {sat_add(r_rdata[3*SW-1:2*SW], res.fz),
                             sat_add(r_rdata[2*SW-1:SW], res.fy),
                             sat_add(r_rdata[SW-1:0], res.fx)};
                n_state   = sfa_pkg::T_U1A;
            end
            sfa_pkg::T_U1A: begin
                mem_raddr = AW'(r_p1);
                n_state   = sfa_pkg::T_U1B;
            end
            sfa_pkg::T_U1B: begin
                mem_we    = r_in1;
                mem_waddr = AW'(r_p1);
                mem_wdata = {sat_add(r_rdata[3*SW-1:2*SW], -res.fz),
                             sat_add(r_rdata[2*SW-1:SW], -res.fy),
                             sat_add(r_rdata[SW-1:0], -res.fx)};
                n_state   = sfa_pkg::T_IDLE;
            end
            default: begin
                n_state = sfa_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sfa_pkg::T_CLEAR;
            r_clr        <= '0;
            r_force_type <= sfa_pkg::FT_UNIFORM;
            r_stiffness  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfa_pkg::CFG_FORCE_TYPE: r_force_type <= i_cfg_data[1:0];
                    sfa_pkg::CFG_STIFFNESS:  r_stiffness  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0  <= i_first_point;
            r_p1  <= i_second_point;
            r_in0 <= 17'(i_first_point) < 17'(MAX_POINTS);
            r_in1 <= 17'(i_second_point) < 17'(MAX_POINTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign o_busy    = (r_state != sfa_pkg::T_IDLE);
    assign o_valid   = (r_state == sfa_pkg::T_RD1);
    assign o_point   = r_p0;
    assign o_total_x = r_in0 ? r_rdata[SW-1:0] : '0;
    assign o_total_y = r_in0 ? r_rdata[2*SW-1:SW] : '0;
    assign o_total_z = r_in0 ? r_rdata[3*SW-1:2*SW] : '0;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> r_state == sfa_pkg::T_CALC)
        else $error("force unit finished outside of a spring transfer");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state != sfa_pkg::T_IDLE)
        else $error("store written while idle");

endmodule
`default_nettype wire
